// ----- rtl/fat12_cluster_chain_walker_defines.svh -----
// ----------------------------------------------------------------------------
// fat12 chain walker assertion macros
// Shared property wrappers for the checkers of the chain walker. Each macro
// expects signals named clock and reset in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef FAT12_CLUSTER_CHAIN_WALKER_DEFINES_SVH
`define FAT12_CLUSTER_CHAIN_WALKER_DEFINES_SVH

// implication checked on every clock edge outside reset
`define FAT12_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// condition that must never be seen outside reset
`define FAT12_NEVER(lbl, expr, msg) \
   `FAT12_ASSERT(lbl, !(expr), msg)

`endif

// ----- rtl/fat12_pkg.sv -----
// ----------------------------------------------------------------------------
// fat12 chain walker package
// Item types, command and status codes and fixed sizes of the chain walker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fat12_pkg;

   localparam int CMD_W     = 2;
   localparam int IDX_W     = 13;
   localparam int BYTE_W    = 8;
   localparam int CLUSTER_W = 12;
   localparam int SIZE_W    = 32;
   localparam int SECTOR_W  = 16;
   localparam int COUNT_W   = 10;
   localparam int STATUS_W  = 2;

   localparam int SECTOR_BYTES = 512;
   localparam int SECT_SHIFT   = $clog2(SECTOR_BYTES);

   localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_START = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CONT  = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_PAUSED = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EOF    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BROKEN = 2'd2;

   localparam logic [CLUSTER_W-1:0] ENTRY_MIN = 12'h002;
   localparam logic [CLUSTER_W-1:0] ENTRY_BAD = 12'hff7;
   localparam logic [CLUSTER_W-1:0] ENTRY_END = 12'hff8;

   localparam logic [SECTOR_W-1:0] OFFSET_RESET = 16'd31;

   typedef struct packed {
      logic [CMD_W-1:0]     command;
      logic [IDX_W-1:0]     byte_index;
      logic [BYTE_W-1:0]    byte_value;
      logic [CLUSTER_W-1:0] start_cluster;
      logic [SIZE_W-1:0]    size_bytes;
   } req_type;

   typedef struct packed {
      logic [SECTOR_W-1:0] sector;
      logic [COUNT_W-1:0]  byte_count;
      logic                last;
      logic [STATUS_W-1:0] status;
   } rsp_type;

   // table memory access command, one write and one read
   typedef struct packed {
      logic              wr_en;
      logic [IDX_W-1:0]  wr_addr;
      logic [BYTE_W-1:0] wr_data;
      logic              rd_en;
      logic [IDX_W-1:0]  rd_addr;
   } ram_cmd_type;

endpackage

// ----- rtl/fat12_cluster_chain_walker.sv -----
// ----------------------------------------------------------------------------
// fat12 cluster chain walker
// Holds a 12-bit allocation table as a byte memory and follows cluster chains,
// reporting the data sector and byte count of every cluster of a file.
// ----------------------------------------------------------------------------
// A load item writes one table byte; busy stays low. A start item with a
// good cluster or a continue item after a pause raises busy: state ADDR sets
// up the first read, then each cluster passes through states HI and LO,
// because its packed 12-bit entry needs two byte reads in sequence through
// the single read port of the table memory. The first result follows
// states ADDR, HI and LO; each result is registered from state LO, at most
// MAX_RUN per item. busy falls with the final result, so the next item can
// be taken while it is shown. A bad start cluster gives its one result in
// the next cycle and never raises busy. Results are shown for one cycle
// only and the receiver cannot hold them off; rsp_valid marks them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fat12_cluster_chain_walker #(
   parameter int TABLE_BYTES = 6144,
   parameter int MAX_RUN     = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  fat12_pkg::req_type                  req_data,
   output logic                                rsp_valid,
   output fat12_pkg::rsp_type                  rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [fat12_pkg::SECTOR_W-1:0]      csr_wdata
);

   localparam int RUN_W = $clog2(MAX_RUN + 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_ADDR = 2'd1;
   localparam logic [1:0] ST_HI   = 2'd2;
   localparam logic [1:0] ST_LO   = 2'd3;

   localparam logic [fat12_pkg::IDX_W-1:0] TABLE_END = fat12_pkg::IDX_W'(TABLE_BYTES);

   // byte position of an entry: floor(c * 3 / 2)
   function automatic logic [fat12_pkg::IDX_W-1:0] entry_base(
      input logic [fat12_pkg::CLUSTER_W-1:0] c
   );
      logic [fat12_pkg::IDX_W:0] t;
      t = {2'b00, c} + {1'b0, c, 1'b0};
      return t[fat12_pkg::IDX_W:1];
   endfunction

   logic [1:0]                        state_ff, state_in;
   logic [fat12_pkg::CLUSTER_W-1:0]   cluster_ff, cluster_in;
   logic [fat12_pkg::SIZE_W-1:0]      remain_ff, remain_in;
   logic                              paused_ff, paused_in;
   logic [fat12_pkg::SECTOR_W-1:0]    offset_ff, offset_in;
   logic [RUN_W-1:0]                  run_cnt_ff, run_cnt_in;
   logic [fat12_pkg::IDX_W-1:0]       rd_base_ff, rd_base_in;
   logic [fat12_pkg::BYTE_W-1:0]      b0_ff, b0_in;
   logic                              oob_ff, oob_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   fat12_pkg::rsp_type                rsp_ff, rsp_in;

   fat12_pkg::ram_cmd_type            ram_cmd;
   logic [fat12_pkg::BYTE_W-1:0]      ram_rd_data;
   logic [fat12_pkg::BYTE_W-1:0]      byte_eff;
   logic [fat12_pkg::CLUSTER_W-1:0]   entry;
   logic [fat12_pkg::IDX_W-1:0]       next_base;
   logic [fat12_pkg::SECTOR_W-1:0]    sector;
   logic [fat12_pkg::COUNT_W-1:0]     tail_count;
   logic                              accept;
   logic                              rd_req;
   logic [fat12_pkg::IDX_W-1:0]       rd_addr;
   logic                              run_last;
   logic                              start_bad;
   logic                              entry_bad;

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;

   // bytes past the table end read as zero
   assign byte_eff = oob_ff ? '0 : ram_rd_data;
   assign entry    = cluster_ff[0] ? {byte_eff, b0_ff[7:4]} : {byte_eff[3:0], b0_ff};
   assign next_base = entry_base(entry);
   assign sector   = {4'b0000, cluster_ff} + offset_ff;
   assign tail_count = (remain_ff[fat12_pkg::SECT_SHIFT-1:0] == '0)
                     ? fat12_pkg::COUNT_W'(fat12_pkg::SECTOR_BYTES)
                     : fat12_pkg::COUNT_W'(remain_ff[fat12_pkg::SECT_SHIFT-1:0]);
   assign run_last  = (run_cnt_ff == RUN_W'(MAX_RUN - 1));
   assign start_bad = (req_data.start_cluster < fat12_pkg::ENTRY_MIN)
                   || (req_data.start_cluster >= fat12_pkg::ENTRY_BAD);
   assign entry_bad = (entry < fat12_pkg::ENTRY_MIN) || (entry == fat12_pkg::ENTRY_BAD);

   always_comb begin
      state_in     = state_ff;
      cluster_in   = cluster_ff;
      remain_in    = remain_ff;
      paused_in    = paused_ff;
      run_cnt_in   = run_cnt_ff;
      rd_base_in   = rd_base_ff;
      b0_in        = b0_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      rd_req       = 1'b0;
      rd_addr      = rd_base_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_data.command)
                  fat12_pkg::CMD_START: begin
                     remain_in  = req_data.size_bytes;
                     paused_in  = 1'b0;
                     run_cnt_in = '0;
                     if (start_bad) begin
                        cluster_in        = '0;
                        rsp_valid_in      = 1'b1;
                        rsp_in.sector     = '0;
                        rsp_in.byte_count = '0;
                        rsp_in.last       = 1'b1;
                        rsp_in.status     = fat12_pkg::STATUS_BROKEN;
                     end else begin
                        cluster_in = req_data.start_cluster;
                        state_in   = ST_ADDR;
                     end
                  end
                  fat12_pkg::CMD_CONT: begin
                     if (paused_ff) begin
                        run_cnt_in = '0;
                        state_in   = ST_ADDR;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_ADDR: begin
            rd_req     = 1'b1;
            rd_addr    = entry_base(cluster_ff);
            rd_base_in = rd_addr;
            state_in   = ST_HI;
         end
         ST_HI: begin
            rd_req   = 1'b1;
            rd_addr  = rd_base_ff + 1'b1;
            b0_in    = byte_eff;
            state_in = ST_LO;
         end
         ST_LO: begin
            rsp_valid_in      = 1'b1;
            rsp_in.sector     = sector;
            rsp_in.byte_count = fat12_pkg::COUNT_W'(fat12_pkg::SECTOR_BYTES);
            if (entry >= fat12_pkg::ENTRY_END) begin
               rsp_in.byte_count = tail_count;
               rsp_in.last       = 1'b1;
               rsp_in.status     = fat12_pkg::STATUS_EOF;
               paused_in         = 1'b0;
               state_in          = ST_IDLE;
            end else if (entry_bad) begin
               rsp_in.last   = 1'b1;
               rsp_in.status = fat12_pkg::STATUS_BROKEN;
               paused_in     = 1'b0;
               state_in      = ST_IDLE;
            end else if (run_last) begin
               rsp_in.last   = 1'b1;
               rsp_in.status = fat12_pkg::STATUS_PAUSED;
               cluster_in    = entry;
               paused_in     = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               // next cluster: its first byte read goes out in this cycle
               rsp_in.last   = 1'b0;
               rsp_in.status = fat12_pkg::STATUS_PAUSED;
               cluster_in    = entry;
               run_cnt_in    = run_cnt_ff + 1'b1;
               rd_req        = 1'b1;
               rd_addr       = next_base;
               rd_base_in    = next_base;
               state_in      = ST_HI;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign oob_in    = (rd_addr >= TABLE_END);
   assign offset_in = (csr_valid && csr_ready) ? csr_wdata : offset_ff;

   always_comb begin
      ram_cmd.wr_en   = accept && (req_data.command == fat12_pkg::CMD_LOAD)
                     && (req_data.byte_index < TABLE_END);
      ram_cmd.wr_addr = req_data.byte_index;
      ram_cmd.wr_data = req_data.byte_value;
      ram_cmd.rd_en   = rd_req && !oob_in;
      ram_cmd.rd_addr = rd_addr;
   end

   fat12_table_ram #(
      .DEPTH (TABLE_BYTES)
   ) u_table (
      .clock   (clock),
      .cmd     (ram_cmd),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cluster_ff   <= '0;
         remain_ff    <= '0;
         paused_ff    <= 1'b0;
         offset_ff    <= fat12_pkg::OFFSET_RESET;
         run_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cluster_ff   <= cluster_in;
         remain_ff    <= remain_in;
         paused_ff    <= paused_in;
         offset_ff    <= offset_in;
         run_cnt_ff   <= run_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_base_ff <= rd_base_in;
      b0_ff      <= b0_in;
      oob_ff     <= oob_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- rtl/fat12_table_ram.sv -----
// ----------------------------------------------------------------------------
// fat12 table byte memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fat12_table_ram #(
   parameter int DEPTH = 6144
) (
   input  logic                                 clock,
   input  fat12_pkg::ram_cmd_type               cmd,
   output logic [fat12_pkg::BYTE_W-1:0]         rd_data
);

   localparam int ADDR_W = $clog2(DEPTH);

   logic [fat12_pkg::BYTE_W-1:0] mem [DEPTH];
   logic [fat12_pkg::BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[cmd.wr_addr[ADDR_W-1:0]] <= cmd.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_data_ff <= mem[cmd.rd_addr[ADDR_W-1:0]];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/fat12_checker.sv -----
// ----------------------------------------------------------------------------
// fat12 chain walker port checker
// Watches the ports of the chain walker over time; bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "fat12_cluster_chain_walker_defines.svh"

module fat12_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                start,
   input logic                                busy,
   input fat12_pkg::req_type                  req_data,
   input logic                                rsp_valid,
   input fat12_pkg::rsp_type                  rsp_data,
   input logic                                csr_valid,
   input logic                                csr_ready
);

   logic load_taken;
   logic cfg_taken;

   assign load_taken = start && !busy && (req_data.command == fat12_pkg::CMD_LOAD);
   assign cfg_taken  = csr_valid && csr_ready;

   // a result that is not the last one leaves the walk running
   `FAT12_ASSERT(a_more_keeps_busy,
      rsp_valid && !rsp_data.last |-> busy && rsp_data.status == fat12_pkg::STATUS_PAUSED,
      "non-last result without a running walk")

   // a load item causes no result
   `FAT12_ASSERT(a_load_silent, load_taken |=> !rsp_valid, "result after a load item")

   // an empty count only comes from a bad start cluster
   `FAT12_ASSERT(a_zero_count_bad_start,
      rsp_valid && rsp_data.byte_count == '0 |-> rsp_data.last
         && rsp_data.status == fat12_pkg::STATUS_BROKEN && rsp_data.sector == '0,
      "zero byte count on a regular result")

   // busy only rises after an item was taken
   `FAT12_ASSERT(a_busy_after_start, $rose(busy) |-> $past(start), "busy rose without an item")

   // the user keeps register writes to idle; the block does not enforce it
   `FAT12_NEVER(a_cfg_while_busy, cfg_taken && busy, "register write during a walk")

endmodule

bind fat12_cluster_chain_walker fat12_checker u_fat12_checker (.*);
